// ----- sv/mva_pkg.sv -----
// ---------------------------------------------------------------------------
// mva_pkg
// Widths and step counts shared by the mean and variance accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

  // item fields
  localparam int SampleWidth = 16;
  localparam int CountWidth  = 16;
  localparam int FracBits    = 16;
  localparam int SumWidth    = 32;
  localparam int SqWidth     = 47;
  localparam int MeanWidth   = 32;
  localparam int VarWidth    = 47;

  // saturation point of the sample counter
  localparam logic [CountWidth-1:0] CountMax = '1;

  // shared datapath: 64-bit adder, shift-add multiply, restoring divide
  localparam int ProdWidth  = 64;
  localparam int MulWidth   = 32;
  localparam int DivisorW   = 32;
  localparam int DivWidth   = ProdWidth + FracBits;
  localparam int MulSteps   = MulWidth;
  localparam int DivSteps   = DivWidth;
  localparam int StepWidth  = $clog2(DivSteps + 1);

endpackage : mva_pkg

`default_nettype wire

// ----- sv/mean_variance_accumulator.sv -----
// ---------------------------------------------------------------------------
// mean_variance_accumulator
// Per-set count, sum and sum of squares; mean and population variance in
// fixed point (16 fraction bits) once the last item of a set arrives.
// ---------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o    | in_sample_i, in_last_i
//  out     | out_valid_o / out_stall_i  | out_mean_o, out_variance_o,
//          |                            | out_sample_count_o, out_overflow_o
//
//  - Samples without the last mark are taken whenever idle: items stream back to back.
//  - A last sample starts a result pass before the result can load: abs,
//    two 32-step shift-add multiplies, subtract, a third multiply, two
//    80-step restoring divides, sign fix. All of it runs through one
//    64-bit add/subtract unit.
//  - in_stall_o is high for the whole result pass and while a finished result
//    waits behind a still-full output register.
//  - The output register lets new samples be taken while a result is unread.
//  - rst_ni clears the accumulators, the sequencer and out_valid_o.
// ---------------------------------------------------------------------------
`default_nettype none

module mean_variance_accumulator (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire signed [mva_pkg::SampleWidth-1:0] in_sample_i,
  input  wire                                 in_last_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [mva_pkg::MeanWidth-1:0] out_mean_o,
  output logic [mva_pkg::VarWidth-1:0]        out_variance_o,
  output logic [mva_pkg::CountWidth-1:0]      out_sample_count_o,
  output logic                                out_overflow_o
);
  import mva_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS  = 4'd1;  // |sum|
  localparam logic [3:0] S_MULA = 4'd2;  // n * sumsq
  localparam logic [3:0] S_MULB = 4'd3;  // |sum|^2
  localparam logic [3:0] S_SUB  = 4'd4;  // d = max(a - b, 0)
  localparam logic [3:0] S_MULN = 4'd5;  // n^2
  localparam logic [3:0] S_DIVV = 4'd6;  // d * 2^F / n^2
  localparam logic [3:0] S_DIVM = 4'd7;  // |sum| * 2^F / n
  localparam logic [3:0] S_NEG  = 4'd8;  // restore sign of the mean
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_q, state_d;

  // accumulators
  logic [CountWidth-1:0] count_q;
  logic [SumWidth-1:0]   sum_q;
  logic [SqWidth-1:0]    sumsq_q;
  logic                  drop_q;

  // shared datapath registers
  logic [StepWidth-1:0] step_q, step_d;
  logic [ProdWidth-1:0] acc_q, acc_d;
  logic [ProdWidth-1:0] mcand_q, mcand_d;
  logic [MulWidth-1:0]  mplier_q, mplier_d;
  logic [ProdWidth-1:0] a_q, a_d;
  logic [SumWidth-1:0]  asum_q, asum_d;
  logic [DivisorW-1:0]  div_q, div_d;
  logic [DivWidth-1:0]  dvd_q, dvd_d;
  logic [DivisorW-1:0]  rem_q, rem_d;

  // output register
  logic                  out_valid_q;
  logic [MeanWidth-1:0]  mean_q;
  logic [VarWidth-1:0]   var_q;
  logic [CountWidth-1:0] cnt_q;
  logic                  ovf_q;

  // the one arithmetic unit
  logic [ProdWidth-1:0] alu_a, alu_b;
  logic                 alu_sub;
  logic [ProdWidth:0]   alu_sum;

  logic                  accept;
  logic                  clear;
  logic                  load_out;
  logic [DivisorW:0]     rem_sh;
  logic [ProdWidth-1:0]  mul_acc;
  logic [DivisorW-1:0]   div_rem;
  logic signed [2*SampleWidth-1:0] sq;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // add, or subtract with carry out meaning "no borrow"
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{ProdWidth{1'b0}}, alu_sub};

  // one shift-add multiply step
  assign mul_acc = mplier_q[0] ? alu_sum[ProdWidth-1:0] : acc_q;

  // one restoring divide step
  assign rem_sh  = {rem_q, dvd_q[DivWidth-1]};
  assign div_rem = alu_sum[ProdWidth] ? alu_sum[DivisorW-1:0] : rem_sh[DivisorW-1:0];

  // full-width signed square, never negative
  assign sq = in_sample_i * in_sample_i;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    a_d      = a_q;
    asum_d   = asum_q;
    div_d    = div_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    clear    = 1'b0;
    load_out = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && in_last_i) begin
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        alu_b   = ProdWidth'(sum_q);
        alu_sub = 1'b1;
        asum_d  = sum_q[SumWidth-1] ? alu_sum[SumWidth-1:0] : sum_q;
        acc_d    = '0;
        mcand_d  = ProdWidth'(sumsq_q);
        mplier_d = MulWidth'(count_q);
        step_d   = StepWidth'(MulSteps);
        state_d  = S_MULA;
      end
      S_MULA, S_MULB, S_MULN: begin
        alu_a    = acc_q;
        alu_b    = mcand_q;
        acc_d    = mul_acc;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - 1'b1;
        if (step_q == StepWidth'(1)) begin
          if (state_q == S_MULA) begin
            a_d      = mul_acc;
            acc_d    = '0;
            mcand_d  = ProdWidth'(asum_q);
            mplier_d = asum_q;
            step_d   = StepWidth'(MulSteps);
            state_d  = S_MULB;
          end else if (state_q == S_MULB) begin
            state_d = S_SUB;
          end else begin
            div_d   = mul_acc[DivisorW-1:0];
            dvd_d   = {a_q, {FracBits{1'b0}}};
            rem_d   = '0;
            step_d  = StepWidth'(DivSteps);
            state_d = S_DIVV;
          end
        end
      end
      S_SUB: begin
        alu_a    = a_q;
        alu_b    = acc_q;
        alu_sub  = 1'b1;
        a_d      = alu_sum[ProdWidth] ? alu_sum[ProdWidth-1:0] : '0;
        acc_d    = '0;
        mcand_d  = ProdWidth'(count_q);
        mplier_d = MulWidth'(count_q);
        step_d   = StepWidth'(MulSteps);
        state_d  = S_MULN;
      end
      S_DIVV, S_DIVM: begin
        alu_a   = ProdWidth'(rem_sh);
        alu_b   = ProdWidth'(div_q);
        alu_sub = 1'b1;
        rem_d   = div_rem;
        dvd_d   = {dvd_q[DivWidth-2:0], alu_sum[ProdWidth]};
        step_d  = step_q - 1'b1;
        if (step_q == StepWidth'(1)) begin
          if (state_q == S_DIVV) begin
            a_d     = ProdWidth'(dvd_d[VarWidth-1:0]);
            dvd_d   = DivWidth'({asum_q, {FracBits{1'b0}}});
            div_d   = DivisorW'(count_q);
            rem_d   = '0;
            step_d  = StepWidth'(DivSteps);
            state_d = S_DIVM;
          end else begin
            acc_d   = ProdWidth'(dvd_d[MeanWidth-1:0]);
            state_d = S_NEG;
          end
        end
      end
      S_NEG: begin
        alu_b   = acc_q;
        alu_sub = 1'b1;
        if (sum_q[SumWidth-1]) begin
          acc_d = alu_sum[ProdWidth-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          clear    = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear) begin
        count_q <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        drop_q  <= 1'b0;
      end else if (accept) begin
        if (count_q == CountMax) begin
          drop_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + SumWidth'(in_sample_i);
          sumsq_q <= sumsq_q + SqWidth'(sq);
        end
      end
    end
  end

  // datapath payload, no reset needed
  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    a_q      <= a_d;
    asum_q   <= asum_d;
    div_q    <= div_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mean_q <= acc_q[MeanWidth-1:0];
      var_q  <= a_q[VarWidth-1:0];
      cnt_q  <= count_q;
      ovf_q  <= drop_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_mean_o         = signed'(mean_q);
  assign out_variance_o     = var_q;
  assign out_sample_count_o = cnt_q;
  assign out_overflow_o     = ovf_q;

`ifndef SYNTHESIS
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_last_i) |=> (state_q == S_ABS))
    else $error("last item did not start the result pass");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i))
      |=> (out_valid_o && count_q == '0 && state_q == S_IDLE))
    else $error("result load did not clear the accumulators");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVV || state_q == S_DIVM) |-> (rem_q < div_q))
    else $error("divider remainder out of range");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_sample_count_o != '0))
    else $error("result with empty count");
`endif

endmodule : mean_variance_accumulator

`default_nettype wire
